### sv/hts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants for the head/tail sample taper
// Register indexes, status codes and the fixed constants of the Q30
// cosine table build.
// ----------------------------------------------------------------------------
package hts_pkg;

  // Fixed field widths
  localparam int IDX_W     = 24;  // sample index within a record
  localparam int CFG_W     = 24;  // configuration write data
  localparam int CFG_IDX_W = 3;   // configuration register index
  localparam int STATUS_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_END      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_START    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_END      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 3'd5;

  localparam logic [CFG_W-1:0] RECORD_LENGTH_RST = 24'd1024;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_HEAD_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TAIL_ERR = 2'd2;

  // Q30 constants for the cosine table
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // Taylor series denominators (2k-1)*(2k), k = 1..9
  localparam longint unsigned TAYLOR_DEN [9] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };

endpackage

### sv/hts_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_ifs: channel interfaces of the head/tail sample taper
// Valid/ready channels for samples in, tapered samples out and register
// writes.
// ----------------------------------------------------------------------------

// Sample input channel
interface hts_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;
  logic                          record_last;

  modport source (output valid, sample_x, sample_y, sample_z, record_last, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, record_last, output ready);
endinterface

// Tapered sample output channel
interface hts_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] tapered_x;
  logic signed [SAMPLE_BITS-1:0] tapered_y;
  logic signed [SAMPLE_BITS-1:0] tapered_z;
  logic                          out_last;
  logic [1:0]                    taper_status;

  modport source (output valid, tapered_x, tapered_y, tapered_z, out_last, taper_status,
                  input ready);
  modport sink   (input valid, tapered_x, tapered_y, tapered_z, out_last, taper_status,
                  output ready);
endinterface

// Register write channel
interface hts_cfg_if import hts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/head_tail_sample_taper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// head_tail_sample_taper: linear or raised cosine head/tail record taper
// Counts the sample index within each record, forms a Q1.F weight from a
// head ramp and a tail ramp, and scales all three components by it.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  in_if    | sink      | sample_x, sample_y, sample_z, record_last
//  out_if   | source    | tapered_x, tapered_y, tapered_z, out_last, taper_status
//  cfg_if   | sink      | index, data (always ready)
//
//  One transaction at a time. With QB = max(WEIGHT_FRAC_BITS+1,
//  clog2(COS_TABLE_ENTRIES)), each ramp whose slope a sample falls on
//  goes through the shared restoring divider (one quotient bit per cycle)
//  for QB quotient bits, and with cosine ramps then through a table read
//  and the weight step. A head error skips the ramps and the combine.
//  The three components go through one shared multiplier.
//  Reset (rst_n, synchronous) clears the sequencer, index, output valid and configuration registers.
//  A stalled output holds its result; the next input transaction may be
//  accepted and worked on meanwhile, waiting only at its final write.
//
module head_tail_sample_taper import hts_pkg::*; #(
  parameter int SAMPLE_BITS       = 24,
  parameter int WEIGHT_FRAC_BITS  = 15,
  parameter int COS_TABLE_ENTRIES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  hts_in_if.sink    in_if,
  hts_out_if.source out_if,
  hts_cfg_if.sink   cfg_if
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int AW   = $clog2(COS_TABLE_ENTRIES);
  localparam int EB   = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int QB   = (F + 1 > AW) ? F + 1 : AW;
  localparam int SHW  = (F > EB) ? F : EB;
  localparam int NUMW = IDX_W + SHW;
  localparam int CW   = NUMW + QB;
  localparam int CNTW = $clog2(QB);
  localparam int MA   = (S > F + 2) ? S : F + 2;
  localparam int PW   = MA + F + 2;
  localparam int PX   = IDX_W + 2;

  localparam logic [F:0]    W_ONE   = {1'b1, {F{1'b0}}};
  localparam logic [F:0]    W_ZERO  = '0;
  localparam logic [PW-1:0] MUL_HALF = PW'(1) << (F - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RAMP   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_COS_RD = 3'd3;
  localparam logic [2:0] ST_COS    = 3'd4;
  localparam logic [2:0] ST_WMUL   = 3'd5;
  localparam logic [2:0] ST_APPLY  = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  // --------------------------------------------------------------------------
  // Cosine table, Q30, over [0, pi), built at elaboration
  // --------------------------------------------------------------------------
  typedef logic signed [31:0] cos_rom_t [COS_TABLE_ENTRIES];

  function automatic logic signed [31:0] cos_q30(input longint unsigned p);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    logic            neg;
    x   = (PI_Q30 * p) / 64'(COS_TABLE_ENTRIES);
    neg = 1'b0;
    if (x > PI_Q30 / 2) begin
      x   = (x > PI_Q30) ? 64'd0 : PI_Q30 - x;
      neg = 1'b1;
    end
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int k = 1; k <= 9; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DEN[k-1];
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    return neg ? 32'(-sum) : 32'(sum);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int p = 0; p < COS_TABLE_ENTRIES; p++) begin
      rom[p] = cos_q30(64'(p));
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic                     mode_r;
  logic signed [CFG_W-1:0]  hs_r, he_r, ts_r, te_r;
  logic [CFG_W-1:0]         rlen_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [2:0]               state_r, state_nxt;

  logic signed [S-1:0]      smp_r [3];
  logic signed [S-1:0]      smp_nxt [3];
  logic signed [S-1:0]      res_r [3];
  logic signed [S-1:0]      res_nxt [3];
  logic                     last_r, last_nxt;
  logic [IDX_W-1:0]         n_r, n_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic                     sel_r, sel_nxt;
  logic [F:0]               wh_r, wh_nxt;
  logic [F:0]               wt_r, wt_nxt;
  logic [F:0]               w_r, w_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic [CW-1:0]            dv_r, dv_nxt;
  logic [QB-1:0]            q_r, q_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic signed [31:0]       cos_r, cos_nxt;
  logic [1:0]               comp_r, comp_nxt;

  logic                     ov_r, ov_nxt;
  logic signed [S-1:0]      ox_r, oy_r, oz_r;
  logic                     olast_r;
  logic [STATUS_W-1:0]      ostat_r;
  logic                     oload;

  // --------------------------------------------------------------------------
  // Configuration decode and ramp setup
  // --------------------------------------------------------------------------
  logic signed [PX-1:0] hs_x, he_x, ts_x, te_x, n_x, rs_x, re_x, rlen_m1;
  logic                 head_on, tail_on, head_err, tail_err;
  logic                 ramp_on, rising;
  logic [IDX_W-1:0]     span, off, down;
  logic [NUMW-1:0]      numer;

  assign hs_x    = PX'(hs_r);
  assign he_x    = PX'(he_r);
  assign ts_x    = PX'(ts_r);
  assign te_x    = PX'(te_r);
  assign n_x     = $signed({2'b00, n_r});
  assign rlen_m1 = $signed({2'b00, rlen_r}) - PX'(1);

  assign head_on  = he_x > hs_x;
  assign tail_on  = te_x > ts_x;
  assign head_err = head_on && (rlen_m1 < hs_x);
  assign tail_err = !head_err && tail_on && te_r[CFG_W-1];

  // Current ramp: head first, then tail
  assign rising  = !sel_r;
  assign rs_x    = sel_r ? ts_x : hs_x;
  assign re_x    = sel_r ? te_x : he_x;
  assign ramp_on = sel_r ? (tail_on && (status_r != STATUS_TAIL_ERR)) : head_on;

  assign span = IDX_W'(re_x - rs_x);
  assign off  = IDX_W'(n_x - rs_x);
  assign down = IDX_W'(re_x - n_x);

  // Divider dividend: cosine phase or linear weight scaled by 2^F
  always_comb begin
    if (mode_r) begin
      numer = NUMW'(off) * NUMW'(COS_TABLE_ENTRIES);
    end else begin
      numer = NUMW'(rising ? off : down) << F;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider step (one quotient bit)
  // --------------------------------------------------------------------------
  logic          div_ge;
  logic [QB-1:0] q_step;

  assign div_ge = rem_r >= dv_r;
  assign q_step = {q_r[QB-2:0], div_ge};

  // --------------------------------------------------------------------------
  // Raised cosine weight from the table value
  // --------------------------------------------------------------------------
  logic signed [33:0] cv, cv_clip;
  logic [33:0]        cv_rnd;
  logic [F:0]         cos_w;

  always_comb begin
    cv = sel_r ? (34'sd1073741824 + 34'(cos_r)) : (34'sd1073741824 - 34'(cos_r));
    if (cv < 34'sd0) begin
      cv_clip = '0;
    end else if (cv > 34'sd2147483648) begin
      cv_clip = 34'sd2147483648;
    end else begin
      cv_clip = cv;
    end
    cv_rnd = unsigned'(cv_clip) + (34'd1 << (30 - F));
    cos_w  = cv_rnd[31:31-F];
    if (cos_w > W_ONE) cos_w = W_ONE;
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic signed [MA-1:0]  mul_a;
  logic signed [F+1:0]   mul_b;
  logic signed [PW-1:0]  prod, prod_rnd, prod_sh;

  always_comb begin
    if (state_r == ST_WMUL) begin
      mul_a = $signed(MA'(wh_r));
      mul_b = $signed({1'b0, wt_r});
    end else begin
      mul_a = MA'(smp_r[comp_r]);
      mul_b = $signed({1'b0, w_r});
    end
  end

  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign prod_rnd = prod + $signed(MUL_HALF);
  assign prod_sh  = prod_rnd >>> F;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic       in_acc;
  logic       store_en;
  logic [F:0] store_w;

  assign in_acc = in_if.valid && in_if.ready;
  assign oload  = (state_r == ST_OUT) && (!ov_r || out_if.ready);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    smp_nxt    = smp_r;
    res_nxt    = res_r;
    last_nxt   = last_r;
    n_nxt      = n_r;
    status_nxt = status_r;
    sel_nxt    = sel_r;
    wh_nxt     = wh_r;
    wt_nxt     = wt_r;
    w_nxt      = w_r;
    rem_nxt    = rem_r;
    dv_nxt     = dv_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    cos_nxt    = cos_r;
    comp_nxt   = comp_r;
    store_en   = 1'b0;
    store_w    = W_ONE;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          smp_nxt[0] = in_if.sample_x;
          smp_nxt[1] = in_if.sample_y;
          smp_nxt[2] = in_if.sample_z;
          last_nxt   = in_if.record_last;
          n_nxt      = idx_r;
          idx_nxt    = in_if.record_last ? '0 : idx_r + IDX_W'(1);
          sel_nxt    = 1'b0;
          comp_nxt   = '0;
          if (head_err) begin
            status_nxt = STATUS_HEAD_ERR;
            w_nxt      = W_ONE;
            state_nxt  = ST_APPLY;
          end else begin
            status_nxt = tail_err ? STATUS_TAIL_ERR : STATUS_OK;
            state_nxt  = ST_RAMP;
          end
        end
      end

      // Flat parts of the ramp resolve at once, the slope goes to the divider
      ST_RAMP: begin
        priority if (!ramp_on) begin
          store_en = 1'b1;
          store_w  = W_ONE;
        end else if (n_x < rs_x) begin
          store_en = 1'b1;
          store_w  = rising ? W_ZERO : W_ONE;
        end else if (n_x >= re_x) begin
          store_en = 1'b1;
          store_w  = rising ? W_ONE : W_ZERO;
        end else begin
          rem_nxt   = CW'(numer);
          dv_nxt    = CW'(span) << (QB - 1);
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_ge) rem_nxt = rem_r - dv_r;
        dv_nxt  = dv_r >> 1;
        q_nxt   = q_step;
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(QB - 1)) begin
          if (mode_r) begin
            state_nxt = ST_COS_RD;
          end else begin
            store_en = 1'b1;
            store_w  = q_step[F:0];
          end
        end
      end

      ST_COS_RD: begin
        cos_nxt   = COS_ROM[q_r[AW-1:0]];
        state_nxt = ST_COS;
      end

      ST_COS: begin
        store_en = 1'b1;
        store_w  = cos_w;
      end

      // Combined weight, rounded back to F fraction bits
      ST_WMUL: begin
        w_nxt     = prod_rnd[2*F:F];
        comp_nxt  = '0;
        state_nxt = ST_APPLY;
      end

      // One component per cycle through the shared multiplier
      ST_APPLY: begin
        res_nxt[comp_r] = prod_sh[S-1:0];
        comp_nxt        = comp_r + 2'd1;
        if (comp_r == 2'd2) state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (oload) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Ramp weight done: head goes on to the tail, tail to the combine
    if (store_en) begin
      if (!sel_r) begin
        wh_nxt    = store_w;
        sel_nxt   = 1'b1;
        state_nxt = ST_RAMP;
      end else begin
        wt_nxt    = store_w;
        state_nxt = ST_WMUL;
      end
    end
  end

  assign ov_nxt = oload ? 1'b1 : (out_if.ready ? 1'b0 : ov_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    smp_r    <= smp_nxt;
    res_r    <= res_nxt;
    last_r   <= last_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    sel_r    <= sel_nxt;
    wh_r     <= wh_nxt;
    wt_r     <= wt_nxt;
    w_r      <= w_nxt;
    rem_r    <= rem_nxt;
    dv_r     <= dv_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
    cos_r    <= cos_nxt;
    comp_r   <= comp_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (oload) begin
      ox_r    <= res_r[0];
      oy_r    <= res_r[1];
      oz_r    <= res_r[2];
      olast_r <= last_r;
      ostat_r <= status_r;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      hs_r   <= '0;
      he_r   <= '0;
      ts_r   <= '0;
      te_r   <= '0;
      rlen_r <= RECORD_LENGTH_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_TAPER_MODE:    mode_r <= cfg_if.data[0];
        REG_HEAD_START:    hs_r   <= $signed(cfg_if.data);
        REG_HEAD_END:      he_r   <= $signed(cfg_if.data);
        REG_TAIL_START:    ts_r   <= $signed(cfg_if.data);
        REG_TAIL_END:      te_r   <= $signed(cfg_if.data);
        REG_RECORD_LENGTH: rlen_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign cfg_if.ready        = 1'b1;
  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = ov_r;
  assign out_if.tapered_x    = ox_r;
  assign out_if.tapered_y    = oy_r;
  assign out_if.tapered_z    = oz_r;
  assign out_if.out_last     = olast_r;
  assign out_if.taper_status = ostat_r;

endmodule

### sim/head_tail_sample_taper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// head_tail_sample_taper_test: self-checking bench for the record taper
// Streams three-component samples in records through the taper under many
// head/tail window settings, linear and cosine. Every sample is predicted in
// the bench and each tapered transaction is checked field by field.
// ----------------------------------------------------------------------------
module head_tail_sample_taper_test;
  import hts_pkg::*;

  localparam int                SMP_W    = 24;
  localparam int                FRAC     = 15;
  localparam int                COS_N    = 1024;
  localparam longint            ONE_W    = 64'sd1 <<< FRAC;
  localparam longint            UNIT_Q30 = 64'sd1073741824;
  localparam longint unsigned   PI_FIX   = 64'd3373259426;

  typedef struct {
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] z;
    logic                    last;
    logic [STATUS_W-1:0]     status;
  } tapered_t;

  // Tracks the window registers and sample index; predicts and checks output
  class taper_tracker;
    longint      cos_fix [COS_N];
    bit          cosine_on;
    longint      head_lo, head_hi, tail_lo, tail_hi, rec_len;
    logic [23:0] index;
    tapered_t    pending [$];
    int          error_count, samples, records, head_flags, tail_flags, cosine_samples;

    function new();
      for (int p = 0; p < COS_N; p++) cos_fix[p] = cos_q30(p);
      cosine_on = 0;
      head_lo = 0; head_hi = 0; tail_lo = 0; tail_hi = 0;
      rec_len = 1024;
      index = '0;
    endfunction

    // Q30 cosine of pi*p/COS_N, Taylor series on the folded angle
    function longint cos_q30(int p);
      longint unsigned ang, ang2, term;
      longint          sum;
      bit              neg;
      ang = (PI_FIX * longint'(p)) / COS_N;
      neg = 0;
      if (ang > PI_FIX / 2) begin
        ang = (ang > PI_FIX) ? 64'd0 : PI_FIX - ang;
        neg = 1;
      end
      ang2 = (ang * ang) >> 30;
      term = UNIT_Q30;
      sum  = UNIT_Q30;
      for (int k = 1; k <= 9; k++) begin
        term = ((term * ang2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      return neg ? -sum : sum;
    endfunction

    // Q30 value in [0, 2] down to a Q1.15 weight, rounded
    function longint q30_to_weight(longint v);
      longint w;
      if (v < 0) v = 0;
      if (v > 2 * UNIT_Q30) v = 2 * UNIT_Q30;
      w = (v + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);
      if (w > ONE_W) w = ONE_W;
      return w;
    endfunction

    function longint ramp(longint n, longint lo, longint hi, bit rising);
      longint span, off, p;
      if (n < lo) return rising ? 0 : ONE_W;
      if (n >= hi) return rising ? ONE_W : 0;
      span = hi - lo;
      off  = n - lo;
      if (cosine_on) begin
        p = (off * COS_N) / span;
        return q30_to_weight(rising ? UNIT_Q30 - cos_fix[p % COS_N]
                                    : UNIT_Q30 + cos_fix[p % COS_N]);
      end
      if (rising) return (off <<< FRAC) / span;
      return ((hi - n) <<< FRAC) / span;
    endfunction

    // Component times weight, round half up, floor shift
    function logic [SMP_W-1:0] scale(logic [SMP_W-1:0] raw, longint w);
      longint v;
      v = longint'(signed'(raw)) * w + (64'sd1 <<< (FRAC - 1));
      v = v >>> FRAC;
      return v[SMP_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_TAPER_MODE:    cosine_on = data[0];
        REG_HEAD_START:    head_lo = longint'(signed'(data));
        REG_HEAD_END:      head_hi = longint'(signed'(data));
        REG_TAIL_START:    tail_lo = longint'(signed'(data));
        REG_TAIL_END:      tail_hi = longint'(signed'(data));
        REG_RECORD_LENGTH: rec_len = longint'(data);
        default: ;
      endcase
    endfunction

    // Accepted input transaction: predict its tapered sample, advance index
    function void take_sample(logic [SMP_W-1:0] x, logic [SMP_W-1:0] y,
                              logic [SMP_W-1:0] z, logic last);
      tapered_t t;
      longint   n, wh, wt, w;
      bit       head_on, tail_on;
      n       = longint'(index);
      head_on = head_hi > head_lo;
      tail_on = tail_hi > tail_lo;
      t.status = STATUS_OK;
      w = ONE_W;
      if (head_on && rec_len - 1 < head_lo) begin
        // head past the record end leaves the sample untouched
        t.status = STATUS_HEAD_ERR;
      end else begin
        wh = head_on ? ramp(n, head_lo, head_hi, 1'b1) : ONE_W;
        wt = ONE_W;
        if (tail_on) begin
          if (tail_hi < 0) t.status = STATUS_TAIL_ERR;
          else wt = ramp(n, tail_lo, tail_hi, 1'b0);
        end
        w = (wh * wt + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      end
      t.x    = scale(x, w);
      t.y    = scale(y, w);
      t.z    = scale(z, w);
      t.last = last;
      pending.push_back(t);
      samples++;
      if (last) records++;
      if (t.status == STATUS_HEAD_ERR) head_flags++;
      if (t.status == STATUS_TAIL_ERR) tail_flags++;
      if (cosine_on) cosine_samples++;
      index = last ? '0 : index + 1'b1;
    endfunction

    function void match_tapered(logic signed [SMP_W-1:0] x, logic signed [SMP_W-1:0] y,
                                logic signed [SMP_W-1:0] z, logic last,
                                logic [STATUS_W-1:0] status);
      tapered_t t;
      if (pending.size() == 0) begin
        $error("tapered transaction with no sample pending: x %0d y %0d z %0d", x, y, z);
        error_count++;
        return;
      end
      t = pending.pop_front();
      if (x !== t.x) begin
        $error("tapered_x expected %0d got %0d", t.x, x);
        error_count++;
      end
      if (y !== t.y) begin
        $error("tapered_y expected %0d got %0d", t.y, y);
        error_count++;
      end
      if (z !== t.z) begin
        $error("tapered_z expected %0d got %0d", t.z, z);
        error_count++;
      end
      if (last !== t.last) begin
        $error("out_last expected %0d got %0d", t.last, last);
        error_count++;
      end
      if (status !== t.status) begin
        $error("taper_status expected %0d got %0d", t.status, status);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   gap_max;
  int   stall_max;

  taper_tracker tracker;

  hts_in_if #(.SAMPLE_BITS(SMP_W)) in_ch ();
  hts_out_if #(.SAMPLE_BITS(SMP_W)) out_ch ();
  hts_cfg_if cfg_ch ();

  head_tail_sample_taper #(
    .SAMPLE_BITS(SMP_W),
    .WEIGHT_FRAC_BITS(FRAC),
    .COS_TABLE_ENTRIES(COS_N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.match_tapered(out_ch.tapered_x, out_ch.tapered_y, out_ch.tapered_z,
                            out_ch.out_last, out_ch.taper_status);
  end

  // Result side backpressure: random stall before each transaction
  initial begin : rx_stall
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, stall_max);
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h800000;
      1:       return 24'h7fffff;
      2:       return SMP_W'($urandom_range(0, 8) - 4);
      default: return SMP_W'($urandom());
    endcase
  endfunction

  // Register write; entered and left at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(idx, value[CFG_W-1:0]);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_taper(input int mode, input int hs, input int he, input int ts,
                           input int te, input int rl);
    write_reg(REG_TAPER_MODE, mode);
    write_reg(REG_HEAD_START, hs);
    write_reg(REG_HEAD_END, he);
    write_reg(REG_TAIL_START, ts);
    write_reg(REG_TAIL_END, te);
    write_reg(REG_RECORD_LENGTH, rl);
  endtask

  // One input transaction; valid stays high on return for back-to-back use
  task automatic send_sample(input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
                             input logic [SMP_W-1:0] z, input logic last);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.sample_x    = x;
    in_ch.sample_y    = y;
    in_ch.sample_z    = z;
    in_ch.record_last = last;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_sample(x, y, z, last);
    @(negedge clk);
  endtask

  // Sender holds off until every tapered sample is back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [SMP_W-1:0] extreme_vals [5];
    int L, hs, he, ts, te, rl, mode, kind, nrec, len, phase;

    tracker = new();
    extreme_vals = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff, 24'h000001};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample_x     = '0;
    in_ch.sample_y     = '0;
    in_ch.sample_z     = '0;
    in_ch.record_last  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_TAPER_MODE;
    cfg_ch.data        = '0;
    gap_max            = 0;
    stall_max          = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset window: no ramp active, samples pass unscaled
    send_sample(24'h800000, 24'h7fffff, 24'h000000, 1'b0);
    send_sample(24'h7fffff, 24'h800000, 24'hffffff, 1'b0);
    send_sample(24'h000001, 24'hffffff, 24'h000000, 1'b0);
    send_sample(rand_sample(), rand_sample(), rand_sample(), 1'b1);
    drain();

    // Short record through both ramps, linear then cosine
    set_taper(0, 1, 5, 6, 9, 12);
    for (int i = 0; i < 10; i++)
      send_sample(extreme_vals[i % 5], extreme_vals[(i + 1) % 5],
                  extreme_vals[(i + 2) % 5], i == 9);
    drain();
    write_reg(REG_TAPER_MODE, 1);
    for (int i = 0; i < 10; i++)
      send_sample(extreme_vals[(i + 3) % 5], extreme_vals[i % 5],
                  extreme_vals[(i + 4) % 5], i == 9);
    drain();

    // Random phases: new window settings, then records of random samples
    phase = 0;
    while (tracker.samples < 870) begin
      kind = (phase < 10) ? phase : $urandom_range(0, 9);
      L    = $urandom_range(4, 40);
      mode = $urandom_range(0, 1);
      rl   = L;
      hs   = $urandom_range(0, L + 4);
      hs  -= 4;
      he   = hs + $urandom_range(0, L);
      ts   = $urandom_range(0, L + 2);
      ts  -= 2;
      te   = ts + $urandom_range(0, L);
      case (kind)
        4: rl = $urandom_range(1, 2 * L);
        5: begin
          // widest spans
          hs = -8388608;
          he = 8388607;
          ts = $urandom_range(0, 1) ? -8388608 : 8;
          te = 8388607;
          rl = 8388608;
        end
        6: begin
          // head starts past the record end
          hs = L + $urandom_range(0, 3);
          he = hs + $urandom_range(1, 8);
          rl = $urandom_range(0, 1) ? L : 0;
          if ($urandom_range(0, 3) == 0) begin
            hs = 8388606;
            he = 8388607;
          end
        end
        7: begin
          // tail wholly before the record start
          te = -int'($urandom_range(1, 20));
          ts = $urandom_range(0, 3) ? te - int'($urandom_range(1, 20)) : -8388608;
        end
        8: begin
          // both ramps off
          hs = $urandom_range(0, L);
          he = hs - int'($urandom_range(0, 5));
          ts = $urandom_range(0, L);
          te = ts - int'($urandom_range(0, 5));
        end
        9: begin
          // record length zero or one
          rl = $urandom_range(0, 1);
          hs = $urandom_range(0, 2);
          hs -= 2;
          he = hs + $urandom_range(1, L);
          if ($urandom_range(0, 1)) begin
            ts = 0;
            te = 8388607;
          end
        end
        default: ;
      endcase
      set_taper(mode, hs, he, ts, te, rl);

      gap_max   = $urandom_range(0, 2) ? 10 : 0;
      stall_max = $urandom_range(0, 2) ? 10 : 0;
      nrec = $urandom_range(2, 4);
      for (int r = 0; r < nrec; r++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * L + 4) : L;
        for (int i = 0; i < len; i++)
          send_sample(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
      end
      drain();
      phase++;
    end

    // Let any stray transaction surface
    repeat (100) @(negedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d tapered samples never came out", tracker.pending.size());
      tracker.error_count++;
    end
    $display("Run: %0d samples in %0d records over %0d window settings, %0d cosine.",
             tracker.samples, tracker.records, phase + 3, tracker.cosine_samples);
    $display("Run: %0d head-position and %0d tail-position faults flagged.",
             tracker.head_flags, tracker.tail_flags);
    if (tracker.error_count == 0) begin
      $display("head_tail_sample_taper: match");
    end else begin
      $display("head_tail_sample_taper: mismatch");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #6_000_000;
    $display("head_tail_sample_taper: mismatch");
    $finish;
  end

endmodule
